[hdl/bhks_pkg.sv]
// Package for the bounded key set unit.
// Holds item types, command codes and controller/datapath interface structs.
// No dependencies.
`default_nettype none
package bhks_pkg;

  localparam int BHKS_CAPACITY = 64;
  localparam int KEY_W         = 64;
  localparam int ROW_W         = 4 * KEY_W;
  localparam int COUNT_OUT_W   = 7;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } bhks_cmd_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [KEY_W-1:0] key_word0;
    logic [KEY_W-1:0] key_word1;
    logic [KEY_W-1:0] key_word2;
    logic [KEY_W-1:0] key_word3;
  } in_item_t;

  typedef struct packed {
    logic                   found;
    logic                   full_res;
    logic [COUNT_OUT_W-1:0] entry_count;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic step;
    logic rd_last;
    logic wr_new;
    logic wr_move;
    logic clr;
  } bhks_ctl_t;

  typedef struct packed {
    bhks_cmd_t cmd;
    logic      hit;
    logic      drained;
    logic      full;
  } bhks_sts_t;

endpackage
`default_nettype wire

[hdl/bounded_hash_key_set_unit.sv]
// Top level of the bounded key set unit: joins controller and datapath.
// Depends on bhks_pkg, bhks_ctrl and bhks_datapath.
//
// Pulse start while busy is low to hand in one item (command and 256-bit
// key). Exactly one result follows, shown for a single cycle with out_valid
// high; the receiver cannot stall it, so capture it then. Lookup, add and
// remove scan held entries one per cycle through the key store's single
// read port. A miss scans every held entry, and an add that misses then
// stores the key unless the set is full; a hit ends the scan early. Remove
// fills the gap with the last entry, so internal order changes but is never
// visible. Clear empties the set without a scan.
`default_nettype none
module bounded_hash_key_set_unit #(
  parameter int CAPACITY = bhks_pkg::BHKS_CAPACITY
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output      logic                busy,
  input  wire bhks_pkg::in_item_t  in_item,
  output      logic                out_valid,
  output      bhks_pkg::out_item_t out_item
);
  import bhks_pkg::*;

  bhks_ctl_t              ctl;
  bhks_sts_t              sts;
  logic [COUNT_OUT_W-1:0] entry_count;
  logic                   found;
  logic                   full_res;

  bhks_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_cmd    (in_item.cmd),
    .sts       (sts),
    .ctl       (ctl),
    .busy      (busy),
    .out_valid (out_valid),
    .found     (found),
    .full_res  (full_res)
  );

  bhks_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_item),
    .ctl         (ctl),
    .sts         (sts),
    .entry_count (entry_count)
  );

  assign out_item.found       = found;
  assign out_item.full_res    = full_res;
  assign out_item.entry_count = entry_count;

endmodule
`default_nettype wire

[hdl/bhks_datapath.sv]
// Datapath of the bounded key set unit: key store memory, scan pipeline,
// entry count and match position. Depends on bhks_pkg.
`default_nettype none
module bhks_datapath #(
  parameter int CAPACITY = bhks_pkg::BHKS_CAPACITY
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire bhks_pkg::in_item_t              in_item,
  input  wire bhks_pkg::bhks_ctl_t             ctl,
  output      bhks_pkg::bhks_sts_t             sts,
  output      logic [bhks_pkg::COUNT_OUT_W-1:0] entry_count
);
  import bhks_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  logic [ROW_W-1:0] mem [CAPACITY];
  logic [ROW_W-1:0] rd_data_r;
  logic [ROW_W-1:0] key_r;
  bhks_cmd_t        cmd_r;
  logic [CW-1:0]    count_r, count_nxt;
  logic [CW-1:0]    scan_r;
  logic [IW-1:0]    cmp_idx_r;
  logic             cmp_vld_r;
  logic [IW-1:0]    pos_r;
  logic [IW-1:0]    rd_addr;
  logic [IW-1:0]    last_idx;
  logic             issue;
  logic             match;
  logic             re;

  assign issue    = ctl.step && (scan_r != count_r);
  assign last_idx = IW'(count_r - CW'(1));
  assign rd_addr  = ctl.rd_last ? last_idx : IW'(scan_r);
  assign re       = issue || ctl.rd_last;
  assign match    = cmp_vld_r && (rd_data_r == key_r);

  always_ff @(posedge clk) begin
    if (re) begin
      rd_data_r <= mem[rd_addr];
    end
    if (ctl.wr_new) begin
      mem[IW'(count_r)] <= key_r;
    end else if (ctl.wr_move) begin
      mem[pos_r] <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      key_r <= {in_item.key_word3, in_item.key_word2,
                in_item.key_word1, in_item.key_word0};
      cmd_r <= bhks_cmd_t'(in_item.cmd);
    end
    if (issue) begin
      cmp_idx_r <= IW'(scan_r);
    end
    if (ctl.step && match) begin
      pos_r <= cmp_idx_r;
    end
  end

  always_comb begin
    count_nxt = count_r;
    priority if (ctl.clr) begin
      count_nxt = '0;
    end else if (ctl.wr_new) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.wr_move) begin
      count_nxt = count_r - CW'(1);
    end else begin
      count_nxt = count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= '0;
      scan_r    <= '0;
      cmp_vld_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (ctl.load) begin
        scan_r    <= '0;
        cmp_vld_r <= 1'b0;
      end else begin
        cmp_vld_r <= issue;
        if (issue) begin
          scan_r <= scan_r + CW'(1);
        end
      end
    end
  end

  assign sts.cmd     = cmd_r;
  assign sts.hit     = match;
  assign sts.drained = (scan_r == count_r) && !cmp_vld_r;
  assign sts.full    = (count_r == CW'(CAPACITY));
  assign entry_count = COUNT_OUT_W'(count_r);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_no_add_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_new |-> count_r != CW'(CAPACITY))
    else $error("store write past capacity");

  a_move_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_move |-> count_r != '0)
    else $error("remove from empty set");

endmodule
`default_nettype wire

[hdl/bhks_ctrl.sv]
// Controller of the bounded key set unit: sequences scan, insert, remove and
// clear, and registers the result flags. Depends on bhks_pkg.
`default_nettype none
module bhks_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [1:0]          in_cmd,
  input  wire bhks_pkg::bhks_sts_t sts,
  output      bhks_pkg::bhks_ctl_t ctl,
  output      logic                busy,
  output      logic                out_valid,
  output      logic                found,
  output      logic                full_res
);
  import bhks_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MV_RD,
    ST_MV_WR,
    ST_WR_NEW,
    ST_CLR,
    ST_FIN
  } state_t;

  state_t state_r;
  logic   found_r;
  logic   full_r;

  always_comb begin
    ctl         = '0;
    ctl.load    = (state_r == ST_IDLE) && start;
    ctl.step    = (state_r == ST_SCAN);
    ctl.rd_last = (state_r == ST_MV_RD);
    ctl.wr_move = (state_r == ST_MV_WR);
    ctl.wr_new  = (state_r == ST_WR_NEW);
    ctl.clr     = (state_r == ST_CLR);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      found_r <= 1'b0;
      full_r  <= 1'b0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            found_r <= 1'b0;
            full_r  <= 1'b0;
            state_r <= (bhks_cmd_t'(in_cmd) == CMD_CLEAR) ? ST_CLR : ST_SCAN;
          end
        end
        ST_SCAN: begin
          priority if (sts.hit) begin
            found_r <= 1'b1;
            state_r <= (sts.cmd == CMD_REMOVE) ? ST_MV_RD : ST_FIN;
          end else if (sts.drained) begin
            if (sts.cmd == CMD_ADD) begin
              if (sts.full) begin
                full_r  <= 1'b1;
                state_r <= ST_FIN;
              end else begin
                state_r <= ST_WR_NEW;
              end
            end else begin
              state_r <= ST_FIN;
            end
          end else begin
            state_r <= ST_SCAN;
          end
        end
        ST_MV_RD:  state_r <= ST_MV_WR;
        ST_MV_WR:  state_r <= ST_FIN;
        ST_WR_NEW: state_r <= ST_FIN;
        ST_CLR:    state_r <= ST_FIN;
        ST_FIN:    state_r <= ST_IDLE;
        default:   state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_FIN);
  assign found     = found_r;
  assign full_res  = full_r;

  a_strobe_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("busy held after result");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(found && full_res))
    else $error("found and full both set");

  a_full_only_add: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && full_res) |-> sts.cmd == CMD_ADD)
    else $error("full flag on non-add item");

endmodule
`default_nettype wire

[sim/bounded_hash_key_set_unit_tb.sv]
// Self-checking testbench for bounded_hash_key_set_unit: directed, capacity and
// random command items, with an in-bench model of the key set.
// Depends on bhks_pkg and bounded_hash_key_set_unit.
`default_nettype none
module bounded_hash_key_set_unit_tb;
  import bhks_pkg::*;

  typedef logic [ROW_W-1:0] key_t;
  typedef enum {MIX_FILL, MIX_CHURN, MIX_DRAIN} mix_t;

  logic      clk     = 1'b0;
  logic      rst_n   = 1'b0;
  logic      start   = 1'b0;
  in_item_t  in_item = '0;
  logic      busy;
  logic      out_valid;
  out_item_t out_item;

  key_t        set_keys [BHKS_CAPACITY];
  int unsigned set_size = 0;
  key_t        recent_keys [$];
  out_item_t   expected_results [$];
  bit          back_to_back = 1'b0;

  int unsigned items_sent   = 0;
  int unsigned cmd_tally [4] = '{default: 0};
  int unsigned hits         = 0;
  int unsigned refusals     = 0;
  int unsigned peak_size    = 0;
  int unsigned results_seen = 0;
  int unsigned mismatches   = 0;

  bounded_hash_key_set_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("bounded_hash_key_set_unit_tb failed");
    $finish;
  end

  function automatic out_item_t apply_to_set(bhks_cmd_t c, key_t k);
    out_item_t r;
    int pos;
    r   = '0;
    pos = -1;
    if (c == CMD_CLEAR) begin
      set_size = 0;
    end else begin
      for (int i = 0; i < set_size; i++) begin
        if (pos < 0 && set_keys[i] == k) pos = i;
      end
      r.found = (pos >= 0);
      if (c == CMD_ADD && pos < 0) begin
        if (set_size >= BHKS_CAPACITY) begin
          r.full_res = 1'b1;
        end else begin
          set_keys[set_size] = k;
          set_size++;
        end
      end else if (c == CMD_REMOVE && pos >= 0) begin
        for (int i = pos; i + 1 < set_size; i++) set_keys[i] = set_keys[i + 1];
        set_size--;
      end
    end
    r.entry_count = COUNT_OUT_W'(set_size);
    return r;
  endfunction

  function automatic key_t fresh_key();
    return {$urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom, $urandom};
  endfunction

  function automatic key_t held_or_fresh();
    if (set_size == 0) return fresh_key();
    return set_keys[$urandom_range(set_size - 1)];
  endfunction

  function automatic key_t near_key();
    key_t k;
    int unsigned b;
    k    = held_or_fresh();
    b    = $urandom_range(ROW_W - 1);
    k[b] = ~k[b];
    return k;
  endfunction

  function automatic key_t pick_key();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 45) return held_or_fresh();
    if (p < 65) return near_key();
    if (p < 80 && recent_keys.size() != 0)
      return recent_keys[$urandom_range(recent_keys.size() - 1)];
    return fresh_key();
  endfunction

  function automatic bhks_cmd_t pick_cmd();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 32) return CMD_LOOKUP;
    if (p < 64) return CMD_ADD;
    if (p < 96) return CMD_REMOVE;
    return CMD_CLEAR;
  endfunction

  task automatic send_item(input bhks_cmd_t c, input key_t k);
    in_item_t    it;
    int unsigned gap;
    out_item_t   r;
    it.cmd       = c;
    it.key_word0 = k[0*KEY_W +: KEY_W];
    it.key_word1 = k[1*KEY_W +: KEY_W];
    it.key_word2 = k[2*KEY_W +: KEY_W];
    it.key_word3 = k[3*KEY_W +: KEY_W];
    gap = back_to_back ? 0 : $urandom_range(19);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (busy !== 1'b0);
    r = apply_to_set(c, k);
    expected_results.push_back(r);
    items_sent++;
    cmd_tally[c]++;
    if (r.found) hits++;
    if (r.full_res) refusals++;
    if (set_size > peak_size) peak_size = set_size;
    if (c != CMD_CLEAR) begin
      recent_keys.push_back(k);
      if (recent_keys.size() > 32) void'(recent_keys.pop_front());
    end
  endtask

  task automatic flag_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at result %0d: %s expected %0d actual %0d",
               results_seen, what, want, got);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        flag_mismatch("unexpected result, pending", 0, 1);
      end else begin
        want = expected_results.pop_front();
        if (out_item.found !== want.found)
          flag_mismatch("found", want.found, out_item.found);
        if (out_item.full_res !== want.full_res)
          flag_mismatch("full_res", want.full_res, out_item.full_res);
        if (out_item.entry_count !== want.entry_count)
          flag_mismatch("entry_count", want.entry_count, out_item.entry_count);
      end
    end
  end

  task automatic test_directed();
    key_t zero_k;
    key_t ones_k;
    key_t alt_k;
    zero_k = '0;
    ones_k = '1;
    back_to_back = 1'b0;
    send_item(CMD_LOOKUP, zero_k);
    send_item(CMD_REMOVE, ones_k);
    send_item(CMD_ADD, zero_k);
    send_item(CMD_ADD, ones_k);
    send_item(CMD_ADD, zero_k);
    send_item(CMD_LOOKUP, ones_k);
    for (int w = 0; w < 4; w++) begin
      alt_k = ones_k;
      alt_k[w*KEY_W +: KEY_W] = '0;
      send_item(CMD_LOOKUP, alt_k);
    end
    alt_k = zero_k;
    alt_k[ROW_W-1] = 1'b1;
    send_item(CMD_REMOVE, alt_k);
    send_item(CMD_REMOVE, zero_k);
    send_item(CMD_LOOKUP, zero_k);
    send_item(CMD_LOOKUP, ones_k);
    send_item(CMD_CLEAR, ones_k);
    send_item(CMD_LOOKUP, ones_k);
    send_item(CMD_CLEAR, zero_k);
    send_item(CMD_ADD, ones_k);
    send_item(CMD_REMOVE, ones_k);
  endtask

  task automatic test_capacity();
    key_t first_k;
    key_t last_k;
    send_item(CMD_CLEAR, fresh_key());
    first_k = fresh_key();
    last_k  = first_k;
    send_item(CMD_ADD, first_k);
    while (set_size < BHKS_CAPACITY) begin
      back_to_back = ((set_size / 16) % 2) != 0;
      last_k = fresh_key();
      send_item(CMD_ADD, last_k);
    end
    back_to_back = 1'b0;
    send_item(CMD_ADD, fresh_key());
    send_item(CMD_ADD, last_k);
    send_item(CMD_LOOKUP, first_k);
    send_item(CMD_LOOKUP, last_k);
    send_item(CMD_REMOVE, last_k);
    send_item(CMD_ADD, last_k);
    send_item(CMD_REMOVE, first_k);
    send_item(CMD_ADD, first_k);
    send_item(CMD_ADD, near_key());
    send_item(CMD_CLEAR, last_k);
    send_item(CMD_LOOKUP, first_k);
  endtask

  task automatic test_random();
    mix_t        mix;
    int unsigned len;
    int unsigned p;
    while (items_sent < 1080) begin
      back_to_back = ($urandom_range(3) == 0);
      p   = $urandom_range(9);
      mix = (p < 3) ? MIX_FILL : ((p < 8) ? MIX_CHURN : MIX_DRAIN);
      case (mix)
        MIX_FILL: begin
          len = $urandom_range(8, 72);
          repeat (len)
            send_item(($urandom_range(4) == 0) ? CMD_LOOKUP : CMD_ADD,
                      ($urandom_range(4) == 0) ? pick_key() : fresh_key());
        end
        MIX_CHURN: begin
          len = $urandom_range(10, 40);
          repeat (len) send_item(pick_cmd(), pick_key());
        end
        MIX_DRAIN: begin
          while (set_size != 0)
            send_item(($urandom_range(3) == 0) ? CMD_LOOKUP : CMD_REMOVE,
                      held_or_fresh());
          send_item(CMD_LOOKUP, pick_key());
        end
      endcase
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_capacity();
    test_random();
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    $display("covered %0d items: %0d lookup, %0d add, %0d remove, %0d clear",
             items_sent, cmd_tally[CMD_LOOKUP], cmd_tally[CMD_ADD],
             cmd_tally[CMD_REMOVE], cmd_tally[CMD_CLEAR]);
    $display("%0d results checked, %0d hits, %0d adds refused when full, peak %0d keys",
             results_seen, hits, refusals, peak_size);
    if (mismatches == 0) begin
      $display("bounded_hash_key_set_unit_tb passed");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("bounded_hash_key_set_unit_tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
